>>> rtl/core/tsp_pkg.sv
// Shared types, constants and helpers for the tone sequence player.
`default_nettype none
package tsp_pkg;

    // Note store geometry
    localparam int NOTE_SLOTS = 8;
    localparam int IDX_W      = (NOTE_SLOTS > 1) ? $clog2(NOTE_SLOTS) : 1;
    localparam int CNT_W      = $clog2(NOTE_SLOTS + 1);

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_VOLUME = 1'b1;

    localparam logic [6:0] VOL_MAX   = 7'd100;
    localparam logic [7:0] LEVEL_MAX = 8'd255;

    // Command codes of an input item
    typedef enum logic [1:0] {
        CMD_TICK = 2'd0,
        CMD_LOAD = 2'd1,
        CMD_STOP = 2'd2
    } t_cmd;

    // One stored note
    typedef struct packed {
        logic [15:0] freq;
        logic [15:0] dur;
        logic [15:0] gap;
    } t_note;

    localparam int NOTE_W = $bits(t_note);

    // Input item as seen by the sequencer
    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] note_freq;
        logic [15:0] note_duration_ms;
        logic [15:0] note_gap_ms;
        logic        last_note;
    } t_item;

    // Control from the configuration registers
    typedef struct packed {
        logic enable;
        logic halt;
    } t_ctl;

    // Playback status after the current update
    typedef struct packed {
        logic        tone_on;
        logic [15:0] tone_freq;
        logic        busy;
    } t_stat;

    // Speaker level: vol * 255 / 100, the divide done as a reciprocal multiply
    function automatic logic [7:0] level_of(input logic [6:0] vol);
        logic [14:0] prod;
        logic [27:0] scaled;
        prod   = 15'(vol) * 15'd255;
        scaled = 28'(prod) * 28'd5243;
        return scaled[26:19];
    endfunction

endpackage
`default_nettype wire

>>> rtl/core/tsp_in_if.sv
// Input item channel of the tone sequence player.
`default_nettype none
interface tsp_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [15:0] note_freq;
    logic [15:0] note_duration_ms;
    logic [15:0] note_gap_ms;
    logic        last_note;

    modport source (output valid, cmd, note_freq, note_duration_ms, note_gap_ms, last_note,
                    input ready);
    modport sink   (input valid, cmd, note_freq, note_duration_ms, note_gap_ms, last_note,
                    output ready);
endinterface
`default_nettype wire

>>> rtl/core/tsp_out_if.sv
// Result item channel of the tone sequence player.
`default_nettype none
interface tsp_out_if;
    logic        valid;
    logic        ready;
    logic        tone_on;
    logic [15:0] tone_freq;
    logic [7:0]  speaker_level;
    logic        sequence_busy;

    modport source (output valid, tone_on, tone_freq, speaker_level, sequence_busy,
                    input ready);
    modport sink   (input valid, tone_on, tone_freq, speaker_level, sequence_busy,
                    output ready);
endinterface
`default_nettype wire

>>> rtl/core/tsp_cfg_if.sv
// Configuration write channel of the tone sequence player.
`default_nettype none
interface tsp_cfg_if;
    logic       valid;
    logic       ready;
    logic [0:0] idx;
    logic [6:0] data;

    modport source (output valid, idx, data, input ready);
    modport sink   (input valid, idx, data, output ready);
endinterface
`default_nettype wire

>>> rtl/core/tsp_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module tsp_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 8,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule
`default_nettype wire

>>> rtl/core/tsp_ctrl.sv
// Note sequencer: playback state, note store access and next-note prefetch.
`default_nettype none
module tsp_ctrl (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_acc,
    input  wire tsp_pkg::t_item          i_item,
    input  wire tsp_pkg::t_ctl           i_ctl,
    output logic                         o_wr_en,
    output logic [tsp_pkg::IDX_W-1:0]    o_wr_addr,
    output logic [tsp_pkg::NOTE_W-1:0]   o_wr_data,
    output logic [tsp_pkg::IDX_W-1:0]    o_rd_addr,
    input  wire logic [tsp_pkg::NOTE_W-1:0] i_rd_data,
    output tsp_pkg::t_stat               o_stat
);
    import tsp_pkg::*;

    // Control state
    logic [CNT_W-1:0] r_lp,     n_lp;
    logic [CNT_W-1:0] r_total,  n_total;
    logic [CNT_W-1:0] r_play,   n_play;
    logic             r_tone,   n_tone;
    logic             r_gap,    n_gap;
    logic [15:0]      r_remain, n_remain;

    // Cached copies: note at the play index and note zero of the sequence
    t_note r_cur,  n_cur;
    t_note r_head, n_head;

    // Forwarding of a write that collides with the prefetch read
    logic  r_fwd_valid;
    t_note r_fwd_data;

    t_note            w_note;
    t_note            w_nxt;
    t_note            w_head;
    logic [CNT_W-1:0] w_play_inc;
    logic [CNT_W-1:0] w_lp;
    logic [CNT_W:0]   w_rd_next;

    assign w_nxt = r_fwd_valid ? r_fwd_data : t_note'(i_rd_data);

    // Next state per item
    always_comb begin
        n_lp       = r_lp;
        n_total    = r_total;
        n_play     = r_play;
        n_tone     = r_tone;
        n_gap      = r_gap;
        n_remain   = r_remain;
        n_cur      = r_cur;
        n_head     = r_head;
        o_wr_en    = 1'b0;
        w_note.freq = i_item.note_freq;
        w_note.dur  = i_item.note_duration_ms;
        w_note.gap  = i_item.note_gap_ms;
        w_play_inc = r_play + CNT_W'(1);
        w_lp       = r_lp;
        w_head     = (r_lp == '0) ? w_note : r_head;

        if (i_acc) begin
            unique case (i_item.cmd)
                CMD_TICK: begin
                    if (i_ctl.enable && r_total != '0) begin
                        if (r_remain > 16'd1) begin
                            n_remain = r_remain - 16'd1;
                        end else begin
                            n_remain = '0;
                            if (r_tone) begin
                                // Tone ends: advance to the next note or finish
                                n_tone = 1'b0;
                                n_play = w_play_inc;
                                if (w_play_inc >= r_total) begin
                                    n_total = '0;
                                    n_gap   = 1'b0;
                                end else begin
                                    n_cur = w_nxt;
                                    if (r_cur.gap != 16'd0) begin
                                        n_gap    = 1'b1;
                                        n_remain = r_cur.gap;
                                    end else begin
                                        n_gap    = 1'b0;
                                        n_tone   = 1'b1;
                                        n_remain = w_nxt.dur;
                                    end
                                end
                            end else begin
                                // Gap ends: sound the current note
                                n_gap    = 1'b0;
                                n_tone   = 1'b1;
                                n_remain = r_cur.dur;
                            end
                        end
                    end
                end
                CMD_LOAD: begin
                    if (i_ctl.enable) begin
                        // First note of a sequence silences playback
                        if (r_lp == '0) begin
                            n_total  = '0;
                            n_play   = '0;
                            n_tone   = 1'b0;
                            n_gap    = 1'b0;
                            n_remain = '0;
                        end
                        // Store the note unless the store is full
                        if (r_lp < CNT_W'(NOTE_SLOTS)) begin
                            o_wr_en = 1'b1;
                            w_lp    = r_lp + CNT_W'(1);
                            if (r_lp == '0) begin
                                n_head = w_note;
                            end
                        end
                        n_lp = w_lp;
                        // Last note starts playback at note zero
                        if (i_item.last_note) begin
                            n_total  = w_lp;
                            n_lp     = '0;
                            n_play   = '0;
                            n_gap    = 1'b0;
                            n_tone   = 1'b1;
                            n_cur    = w_head;
                            n_remain = w_head.dur;
                        end
                    end
                end
                CMD_STOP: begin
                    n_lp     = '0;
                    n_total  = '0;
                    n_play   = '0;
                    n_tone   = 1'b0;
                    n_gap    = 1'b0;
                    n_remain = '0;
                end
                default: begin
                end
            endcase
        end

        // Disable drops playback and any partial sequence
        if (i_ctl.halt) begin
            n_lp     = '0;
            n_total  = '0;
            n_play   = '0;
            n_tone   = 1'b0;
            n_gap    = 1'b0;
            n_remain = '0;
        end
    end

    // Store write and next-note prefetch addresses
    always_comb begin
        o_wr_addr = r_lp[IDX_W-1:0];
        o_wr_data = w_note;
        w_rd_next = {1'b0, n_play} + (CNT_W+1)'(1);
        if (w_rd_next < (CNT_W+1)'(NOTE_SLOTS)) begin
            o_rd_addr = w_rd_next[IDX_W-1:0];
        end else begin
            o_rd_addr = '0;
        end
    end

    // Status after the update
    always_comb begin
        o_stat.tone_on   = n_tone;
        o_stat.tone_freq = n_tone ? n_cur.freq : 16'd0;
        o_stat.busy      = n_tone | n_gap;
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lp        <= '0;
            r_total     <= '0;
            r_play      <= '0;
            r_tone      <= 1'b0;
            r_gap       <= 1'b0;
            r_remain    <= '0;
            r_fwd_valid <= 1'b0;
        end else begin
            r_lp        <= n_lp;
            r_total     <= n_total;
            r_play      <= n_play;
            r_tone      <= n_tone;
            r_gap       <= n_gap;
            r_remain    <= n_remain;
            r_fwd_valid <= o_wr_en && (o_wr_addr == o_rd_addr);
        end
    end

    // Payload caches
    always_ff @(posedge i_clk) begin
        r_cur      <= n_cur;
        r_head     <= n_head;
        r_fwd_data <= w_note;
    end

`ifndef SYNTH
    a_tone_gap_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_tone && r_gap))
        else $error("tone and gap active together");
    a_play_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tone |-> (r_play < r_total))
        else $error("sounding note beyond sequence length");
    a_gap_has_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_gap |-> (r_remain != 16'd0))
        else $error("gap active with no time left");
    a_lp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lp <= CNT_W'(NOTE_SLOTS))
        else $error("load pointer past store size");
`endif

endmodule
`default_nettype wire

>>> rtl/core/tone_sequence_player_top.sv
// Top level of the tone sequence player: channels, configuration and result register.
// Result timing: a result item is valid in the cycle after its input item is accepted.
// Throughput: one item per cycle; input is taken while a result waits if the
//   result is taken in the same cycle, the note store read is
//   prefetched so no item stalls on it.
// Reset: synchronous active low; playback idle, enable 1, level 255; note store
//   contents stay undefined until written, there is no clearing pass.
`default_nettype none
module tone_sequence_player_top (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    tsp_in_if.sink      i_note,
    tsp_cfg_if.sink     i_cfg,
    tsp_out_if.source   o_res
);
    import tsp_pkg::*;

    logic       r_enable;
    logic [7:0] r_level;
    logic       r_out_valid;
    t_stat      r_out_stat;
    logic [7:0] r_out_level;

    logic       w_acc;
    logic       w_cfg_wr;
    logic [6:0] w_vol;
    t_item      w_item;
    t_ctl       w_ctl;
    t_stat      w_stat;

    logic                w_wr_en;
    logic [IDX_W-1:0]    w_wr_addr;
    logic [NOTE_W-1:0]   w_wr_data;
    logic [IDX_W-1:0]    w_rd_addr;
    logic [NOTE_W-1:0]   w_rd_data;

    // Handshakes
    assign i_note.ready = !r_out_valid || o_res.ready;
    assign w_acc        = i_note.valid && i_note.ready;
    assign i_cfg.ready  = 1'b1;
    assign w_cfg_wr     = i_cfg.valid && i_cfg.ready;

    assign w_item.cmd              = i_note.cmd;
    assign w_item.note_freq        = i_note.note_freq;
    assign w_item.note_duration_ms = i_note.note_duration_ms;
    assign w_item.note_gap_ms      = i_note.note_gap_ms;
    assign w_item.last_note        = i_note.last_note;

    assign w_ctl.enable = r_enable;
    assign w_ctl.halt   = w_cfg_wr && (i_cfg.idx == CFG_ENABLE) && !i_cfg.data[0];

    // Saturate volume at 100 percent
    assign w_vol = (i_cfg.data > VOL_MAX) ? VOL_MAX : i_cfg.data;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b1;
            r_level  <= LEVEL_MAX;
        end else if (w_cfg_wr) begin
            unique case (i_cfg.idx)
                CFG_ENABLE: r_enable <= i_cfg.data[0];
                CFG_VOLUME: r_level  <= level_of(w_vol);
                default: begin
                end
            endcase
        end
    end

    tsp_ram #(
        .WIDTH (NOTE_W),
        .DEPTH (NOTE_SLOTS)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    tsp_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_acc     (w_acc),
        .i_item    (w_item),
        .i_ctl     (w_ctl),
        .o_wr_en   (w_wr_en),
        .o_wr_addr (w_wr_addr),
        .o_wr_data (w_wr_data),
        .o_rd_addr (w_rd_addr),
        .i_rd_data (w_rd_data),
        .o_stat    (w_stat)
    );

    // Result register: hold until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_acc) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_out_stat  <= w_stat;
            r_out_level <= r_level;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.tone_on       = r_out_stat.tone_on;
    assign o_res.tone_freq     = r_out_stat.tone_freq;
    assign o_res.speaker_level = r_out_level;
    assign o_res.sequence_busy = r_out_stat.busy;

endmodule
`default_nettype wire

>>> tb/sv/tone_sequence_player_top_tb.sv
// Self-checking testbench for the tone sequence player: directed and random note items.
`timescale 1ns / 1ps
module tone_sequence_player_top_tb;
    import tsp_pkg::*;

    localparam int         CLK_HALF_NS  = 4;
    localparam int         STALL_LIMIT  = 3000;
    localparam int         HOLD_CYCLES  = 300;
    localparam int         RANDOM_ITEMS = 900;
    localparam int         PLAY_CAP_MS  = 40;
    localparam int         MAX_REPORTS  = 50;
    localparam logic [1:0] CMD_UNUSED   = 2'd3;

    // Expected result item
    typedef struct packed {
        logic        tone_on;
        logic [15:0] tone_freq;
        logic [7:0]  level;
        logic        busy;
    } t_tone_out;

    logic i_clk;
    logic i_rst_n;

    tsp_in_if  note_ch ();
    tsp_cfg_if cfg_ch ();
    tsp_out_if res_ch ();

    tone_sequence_player_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_note  (note_ch),
        .i_cfg   (cfg_ch),
        .o_res   (res_ch)
    );

    // Player state as the testbench tracks it
    t_note            mdl_store [NOTE_SLOTS];
    logic [CNT_W-1:0] mdl_fill;
    logic [CNT_W-1:0] mdl_total;
    logic [CNT_W-1:0] mdl_pos;
    logic             mdl_sounding;
    logic             mdl_resting;
    logic [15:0]      mdl_left;
    logic             mdl_enable;
    logic [6:0]       mdl_volume;

    t_tone_out expected_q [$];
    int        error_count;
    int        idle_count;
    int        hold_left;
    int        stall_left;
    bit        tx_gaps_on;
    bit        rx_gaps_on;

    // Free-running clock
    always #CLK_HALF_NS i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Player prediction
    // ------------------------------------------------------------------

    function automatic void model_halt();
        mdl_total    = '0;
        mdl_pos      = '0;
        mdl_sounding = 1'b0;
        mdl_resting  = 1'b0;
        mdl_left     = '0;
    endfunction

    function automatic void model_reset();
        foreach (mdl_store[i]) mdl_store[i] = '0;
        mdl_fill   = '0;
        model_halt();
        mdl_enable = 1'b1;
        mdl_volume = VOL_MAX;
    endfunction

    // Sound the note at the play position, or go idle past the end
    function automatic void model_start_note();
        if (mdl_pos >= mdl_total || mdl_pos >= NOTE_SLOTS) begin
            model_halt();
        end else begin
            mdl_sounding = 1'b1;
            mdl_resting  = 1'b0;
            mdl_left     = mdl_store[mdl_pos[IDX_W-1:0]].dur;
        end
    endfunction

    // Advance playback by one millisecond
    function automatic void model_tick();
        logic [15:0] rest_ms;
        logic        advance;
        if (!mdl_enable || mdl_total == 0) return;
        if (mdl_left > 1) begin
            mdl_left--;
            return;
        end
        mdl_left = '0;
        advance  = 1'b1;
        if (mdl_sounding) begin
            mdl_sounding = 1'b0;
            rest_ms = (mdl_pos < NOTE_SLOTS) ? mdl_store[mdl_pos[IDX_W-1:0]].gap : 16'd0;
            mdl_pos++;
            if (mdl_pos >= mdl_total) begin
                mdl_total   = '0;
                mdl_resting = 1'b0;
                advance     = 1'b0;
            end else if (rest_ms != 0) begin
                mdl_resting = 1'b1;
                mdl_left    = rest_ms;
                advance     = 1'b0;
            end
        end
        if (advance) begin
            mdl_resting = 1'b0;
            model_start_note();
        end
    endfunction

    // Store a note; the first of a sequence silences playback, the last starts it
    function automatic void model_load(input t_item it);
        if (!mdl_enable) return;
        if (mdl_fill == 0) model_halt();
        if (mdl_fill < NOTE_SLOTS) begin
            mdl_store[mdl_fill[IDX_W-1:0]] = '{freq: it.note_freq,
                                               dur:  it.note_duration_ms,
                                               gap:  it.note_gap_ms};
            mdl_fill++;
        end
        if (it.last_note) begin
            mdl_total   = mdl_fill;
            mdl_fill    = '0;
            mdl_pos     = '0;
            mdl_resting = 1'b0;
            model_start_note();
        end
    endfunction

    function automatic void model_config(input logic [CFG_IDX_W-1:0]  idx,
                                         input logic [CFG_DATA_W-1:0] data);
        if (idx == CFG_ENABLE) begin
            mdl_enable = data[0];
            if (!mdl_enable) begin
                model_halt();
                mdl_fill = '0;
            end
        end else if (idx == CFG_VOLUME) begin
            mdl_volume = (data > VOL_MAX) ? VOL_MAX : data;
        end
    endfunction

    // Apply one item and return the outputs that follow it
    function automatic t_tone_out model_step(input t_item it);
        t_tone_out res;
        case (it.cmd)
            CMD_TICK: model_tick();
            CMD_LOAD: model_load(it);
            CMD_STOP: begin
                model_halt();
                mdl_fill = '0;
            end
            default: ;
        endcase
        res.tone_on   = mdl_sounding;
        res.tone_freq = (mdl_sounding && mdl_pos < NOTE_SLOTS) ?
                        mdl_store[mdl_pos[IDX_W-1:0]].freq : 16'd0;
        res.level     = 8'((int'(mdl_volume) * int'(LEVEL_MAX)) / int'(VOL_MAX));
        res.busy      = mdl_sounding || mdl_resting;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Idle length: mostly none or short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_item make_note(input logic [15:0] freq, input logic [15:0] dur,
                                        input logic [15:0] gap, input logic last);
        t_item it;
        it.cmd              = CMD_LOAD;
        it.note_freq        = freq;
        it.note_duration_ms = dur;
        it.note_gap_ms      = gap;
        it.last_note        = last;
        return it;
    endfunction

    // Non-load command with random filler in the unused fields
    function automatic t_item make_cmd(input logic [1:0] cmd);
        t_item it;
        it.cmd              = cmd;
        it.note_freq        = 16'($urandom);
        it.note_duration_ms = 16'($urandom);
        it.note_gap_ms      = 16'($urandom);
        it.last_note        = 1'($urandom);
        return it;
    endfunction

    // Note with mostly short timing and the odd full-range value
    function automatic t_item random_note(input logic last);
        logic [15:0] dur;
        logic [15:0] gap;
        int          r;
        r   = $urandom_range(0, 99);
        dur = (r < 88) ? 16'($urandom_range(0, 4)) : 16'($urandom);
        r   = $urandom_range(0, 99);
        if (r < 55)      gap = 16'd0;
        else if (r < 92) gap = 16'($urandom_range(1, 3));
        else             gap = 16'($urandom);
        return make_note(16'($urandom), dur, gap, last);
    endfunction

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // Offer one item after an optional idle gap and predict it once taken
    task automatic send_item(input t_item it);
        int idle_n;
        idle_n = tx_gaps_on ? pick_gap() : 0;
        @(negedge i_clk);
        if (idle_n > 0) begin
            note_ch.valid <= 1'b0;
            repeat (idle_n) @(negedge i_clk);
        end
        note_ch.cmd              <= it.cmd;
        note_ch.note_freq        <= it.note_freq;
        note_ch.note_duration_ms <= it.note_duration_ms;
        note_ch.note_gap_ms      <= it.note_gap_ms;
        note_ch.last_note        <= it.last_note;
        note_ch.valid            <= 1'b1;
        do @(posedge i_clk); while (!note_ch.ready);
        expected_q.push_back(model_step(it));
    endtask

    task automatic send_ticks(input int n);
        repeat (n) send_item(make_cmd(CMD_TICK));
    endtask

    // Drop valid and hold until every result is back, plus the result latency
    task automatic wait_drained();
        @(negedge i_clk);
        note_ch.valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0]  idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_ch.idx   <= idx;
        cfg_ch.data  <= data;
        cfg_ch.valid <= 1'b1;
        do @(posedge i_clk); while (!cfg_ch.ready);
        model_config(idx, data);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Unknown command, tick and stop with nothing loaded
    task automatic test_idle_commands();
        send_item(make_cmd(CMD_UNUSED));
        send_ticks(1);
        send_item(make_cmd(CMD_STOP));
    endtask

    task automatic send_note_pair();
        send_item(make_note(16'hFFFF, 16'd0, 16'd0, 1'b0));
        send_item(make_note(16'h0000, 16'hFFFF, 16'hFFFF, 1'b1));
    endtask

    // Field extremes, zero duration, and a new sequence silencing playback
    task automatic test_note_edges();
        send_note_pair();
        send_ticks(2);
        send_item(make_note(16'h1234, 16'd1, 16'd2, 1'b0));
        send_item(make_cmd(CMD_STOP));
    endtask

    // Tone, rest, then a note chained with no gap to the end of the sequence
    task automatic test_gap_chain();
        send_item(make_note(16'h5555, 16'd1, 16'd2, 1'b0));
        send_item(make_note(16'hAAAA, 16'd2, 16'd0, 1'b1));
        send_ticks(5);
    endtask

    // One note more than the store holds; the dropped one still starts playback
    task automatic test_store_overflow();
        for (int i = 0; i <= NOTE_SLOTS; i++)
            send_item(make_note(16'(100 + i), 16'd0, 16'd0, i == NOTE_SLOTS));
        send_ticks(2);
    endtask

    // Volume extremes and saturation, disable during playback, re-enable
    task automatic test_config_settings();
        wait_drained();
        write_reg(CFG_VOLUME, 7'd0);
        send_ticks(1);
        wait_drained();
        write_reg(CFG_VOLUME, 7'd127);
        send_item(make_note(16'd1000, 16'd5, 16'd0, 1'b1));
        wait_drained();
        // upper data bits carry no meaning for the enable register
        write_reg(CFG_ENABLE, 7'b1111110);
        send_item(make_note(16'd2000, 16'd1, 16'd0, 1'b1));
        send_ticks(1);
        wait_drained();
        write_reg(CFG_ENABLE, 7'd1);
        write_reg(CFG_VOLUME, 7'd55);
        send_ticks(1);
    endtask

    // Hold off results while items are offered, then pause until all are back
    task automatic test_backpressure();
        tx_gaps_on = 1'b0;
        hold_left  = HOLD_CYCLES;
        send_item(make_note(16'd440, 16'd3, 16'd1, 1'b0));
        send_item(make_note(16'd880, 16'd2, 16'd0, 1'b1));
        send_ticks(16);
        wait_drained();
        tx_gaps_on = 1'b1;
    endtask

    // Mostly well-formed sequences played through, with stops and noise mixed in
    task automatic test_random_sequences();
        t_item note_it;
        int    sent;
        int    n;
        int    budget;
        int    plays;
        int    r;
        logic  last;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            tx_gaps_on = ($urandom_range(0, 3) != 0);
            rx_gaps_on = ($urandom_range(0, 3) != 0);

            // change registers between sequences now and then
            if ($urandom_range(0, 7) == 0) begin
                wait_drained();
                write_reg(CFG_VOLUME, 7'($urandom));
                if ($urandom_range(0, 2) == 0) begin
                    write_reg(CFG_ENABLE, {6'($urandom), 1'b0});
                    repeat ($urandom_range(1, 4)) begin
                        note_it = make_cmd(2'($urandom));
                        if (note_it.cmd == CMD_LOAD) note_it = random_note(1'($urandom));
                        send_item(note_it);
                    end
                    wait_drained();
                    write_reg(CFG_ENABLE, {6'($urandom), 1'b1});
                end
            end

            // load a sequence, sometimes too long, cut short or left open
            n = ($urandom_range(0, 99) < 85) ? $urandom_range(1, NOTE_SLOTS)
                                             : $urandom_range(NOTE_SLOTS + 1, NOTE_SLOTS + 3);
            budget = 0;
            for (int i = 0; i < n; i++) begin
                if (i == n - 1) last = ($urandom_range(0, 19) != 0);
                else            last = ($urandom_range(0, 49) == 0);
                note_it = random_note(last);
                if (i < NOTE_SLOTS)
                    budget += ((note_it.note_duration_ms == 0) ? 1 :
                               int'(note_it.note_duration_ms)) + int'(note_it.note_gap_ms);
                send_item(note_it);
                sent++;
                r = $urandom_range(0, 99);
                if (r < 12) begin
                    send_ticks(1);
                    sent++;
                end else if (r < 14) begin
                    send_item(make_cmd(CMD_UNUSED));
                end else if (r < 16 && i != n - 1) begin
                    send_item(make_cmd(CMD_STOP));
                    sent++;
                    break;
                end
            end

            // play it through, now and then stopping early
            plays = ((budget > PLAY_CAP_MS) ? PLAY_CAP_MS : budget) + $urandom_range(0, 3);
            for (int k = 0; k < plays; k++) begin
                r = $urandom_range(0, 199);
                if (r == 0) begin
                    send_item(make_cmd(CMD_STOP));
                    sent++;
                    break;
                end
                if (r == 1) send_item(make_cmd(CMD_UNUSED));
                send_ticks(1);
                sent++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    // Drive ready: long hold-off first, else random stalls
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            res_ch.ready <= 1'b0;
            hold_left--;
        end else if (stall_left > 0) begin
            res_ch.ready <= 1'b0;
            stall_left--;
        end else begin
            res_ch.ready <= 1'b1;
            if (rx_gaps_on) stall_left = pick_gap();
        end
    end

    // Compare each result against the oldest prediction
    always @(posedge i_clk) begin : result_check
        t_tone_out want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (expected_q.size() == 0) begin
                report_mismatch("result item with no item pending");
            end else begin
                want = expected_q.pop_front();
                if (res_ch.tone_on !== want.tone_on)
                    report_mismatch($sformatf("tone_on got %0b expected %0b",
                                              res_ch.tone_on, want.tone_on));
                if (res_ch.tone_freq !== want.tone_freq)
                    report_mismatch($sformatf("tone_freq got %0d expected %0d",
                                              res_ch.tone_freq, want.tone_freq));
                if (res_ch.speaker_level !== want.level)
                    report_mismatch($sformatf("speaker_level got %0d expected %0d",
                                              res_ch.speaker_level, want.level));
                if (res_ch.sequence_busy !== want.busy)
                    report_mismatch($sformatf("sequence_busy got %0b expected %0b",
                                              res_ch.sequence_busy, want.busy));
            end
        end
    end

    // Stop the run when no item moves on any channel for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (note_ch.valid && note_ch.ready) || (res_ch.valid && res_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            idle_count <= 0;
        end else if (idle_count >= STALL_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end else begin
            idle_count <= idle_count + 1;
        end
    end

    // ------------------------------------------------------------------
    // Sequence of tests
    // ------------------------------------------------------------------

    initial begin
        i_clk                    = 1'b0;
        i_rst_n                  = 1'b0;
        note_ch.valid            = 1'b0;
        note_ch.cmd              = CMD_TICK;
        note_ch.note_freq        = '0;
        note_ch.note_duration_ms = '0;
        note_ch.note_gap_ms      = '0;
        note_ch.last_note        = 1'b0;
        cfg_ch.valid             = 1'b0;
        cfg_ch.idx               = CFG_ENABLE;
        cfg_ch.data              = '0;
        res_ch.ready             = 1'b0;
        error_count              = 0;
        idle_count               = 0;
        hold_left                = 0;
        stall_left               = 0;
        tx_gaps_on               = 1'b1;
        rx_gaps_on               = 1'b1;
        model_reset();

        // hold reset, then release it at a falling clock edge
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_idle_commands();
        test_note_edges();
        test_gap_chain();
        test_store_overflow();
        test_config_settings();
        test_backpressure();
        test_random_sequences();

        wait_drained();
        repeat (4) @(posedge i_clk);
        if (expected_q.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_q.size()));
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
